>>> rtl/lng_pkg.sv
// ---------------------------------------------------------------------------
// lng_pkg: shared types and constants of the loudness normalizing gain
// Payload structs, command/status bundles and the fixed-point constants.
// ---------------------------------------------------------------------------
package lng_pkg;

  localparam int SAMPLE_WIDTH_DEF     = 24;
  localparam int MAX_SAMPLES_LOG2_DEF = 16;

  localparam int CFG_AW = 3;
  localparam logic CFG_IDX_TARGET = 1'b0;
  localparam logic CFG_IDX_MAXRED = 1'b1;

  localparam logic signed [14:0] TARGET_RST = -15'sd3584;
  localparam logic        [13:0] MAXRED_RST = 14'd3072;

  localparam logic [63:0] EPS_Q62   = 64'd461168602;
  localparam logic signed [63:0] C_LOG_Q20 = 64'sd808071242;
  localparam logic signed [63:0] LOUD_BIAS = -(64'sd185488900 <<< 24) + (64'sd1 <<< 43);
  localparam logic signed [39:0] K_Q32     = 40'sd2786635;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [63:0] LIN_MAX   = 64'd16777215;

  localparam int DIV_STEPS = 80;
  localparam int LOG_STEPS = 24;
  localparam int EXP_TERMS = 12;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               last;
  } lng_in_t;

  typedef struct packed {
    logic signed [15:0] loudness;
    logic signed [15:0] gain_db;
    logic        [23:0] gain_linear;
    logic               gain_saturated;
  } lng_out_t;

  typedef struct packed {
    logic       div_load;
    logic       div_step;
    logic       x_load;
    logic       norm_step;
    logic       log_init;
    logic       log_step;
    logic       lmul;
    logic       lround;
    logic       gain;
    logic       gmul;
    logic       fmul;
    logic       exp_a;
    logic       exp_b;
    logic [3:0] exp_k;
    logic       out_load;
  } lng_cmd_t;

  typedef struct packed {
    logic last_seen;
    logic norm_done;
    logic out_free;
  } lng_sts_t;

  // ceil(2^36 / k): exact floor division by k for dividends below 2^31
  function automatic logic [36:0] lng_recip(input logic [3:0] k);
    logic [36:0] m;
    case (k)
      4'd1:    m = 37'd68719476736;
      4'd2:    m = 37'd34359738368;
      4'd3:    m = 37'd22906492246;
      4'd4:    m = 37'd17179869184;
      4'd5:    m = 37'd13743895348;
      4'd6:    m = 37'd11453246123;
      4'd7:    m = 37'd9817068106;
      4'd8:    m = 37'd8589934592;
      4'd9:    m = 37'd7635497416;
      4'd10:   m = 37'd6871947674;
      4'd11:   m = 37'd6247225158;
      4'd12:   m = 37'd5726623062;
      default: m = 37'd0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/lng_ctrl.sv
// ---------------------------------------------------------------------------
// lng_ctrl: sequencer of the loudness normalizing gain
// Accepts samples, then steps the datapath through divide, log and exp.
// ---------------------------------------------------------------------------
module lng_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  lng_pkg::lng_sts_t sts,
  output lng_pkg::lng_cmd_t cmd,
  output logic              in_ready
);
  import lng_pkg::*;

  typedef enum logic [13:0] {
    ST_ACC  = 14'b00000000000001,
    ST_LOAD = 14'b00000000000010,
    ST_DIV  = 14'b00000000000100,
    ST_XLD  = 14'b00000000001000,
    ST_NORM = 14'b00000000010000,
    ST_LOG  = 14'b00000000100000,
    ST_LMUL = 14'b00000001000000,
    ST_LRND = 14'b00000010000000,
    ST_GAIN = 14'b00000100000000,
    ST_GMUL = 14'b00001000000000,
    ST_FMUL = 14'b00010000000000,
    ST_EXPA = 14'b00100000000000,
    ST_EXPB = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } lng_state_t;

  lng_state_t state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == ST_ACC) && !sts.last_seen;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.exp_k = cnt_r[3:0];
    case (state_r)
      ST_ACC: begin
        if (sts.last_seen) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) state_nxt = ST_XLD;
      end
      ST_XLD: begin
        cmd.x_load = 1'b1;
        state_nxt  = ST_NORM;
      end
      ST_NORM: begin
        if (sts.norm_done) begin
          cmd.log_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_LOG;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_LOG: begin
        cmd.log_step = 1'b1;
        cnt_nxt      = cnt_r + 7'd1;
        if (cnt_r == 7'(LOG_STEPS - 1)) state_nxt = ST_LMUL;
      end
      ST_LMUL: begin
        cmd.lmul  = 1'b1;
        state_nxt = ST_LRND;
      end
      ST_LRND: begin
        cmd.lround = 1'b1;
        state_nxt  = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = ST_GMUL;
      end
      ST_GMUL: begin
        cmd.gmul  = 1'b1;
        state_nxt = ST_FMUL;
      end
      ST_FMUL: begin
        cmd.fmul  = 1'b1;
        cnt_nxt   = 7'd1;
        state_nxt = ST_EXPA;
      end
      ST_EXPA: begin
        cmd.exp_a = 1'b1;
        state_nxt = ST_EXPB;
      end
      ST_EXPB: begin
        cmd.exp_b = 1'b1;
        if (cnt_r == 7'(EXP_TERMS)) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt   = cnt_r + 7'd1;
          state_nxt = ST_EXPA;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/lng_datapath.sv
// ---------------------------------------------------------------------------
// lng_datapath: arithmetic of the loudness normalizing gain
// Square-accumulate, restoring divider, log2 by squaring, exp by series.
// ---------------------------------------------------------------------------
module lng_datapath #(
  parameter int SAMPLE_WIDTH     = lng_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_SAMPLES_LOG2 = lng_pkg::MAX_SAMPLES_LOG2_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lng_pkg::lng_cmd_t  cmd,
  output lng_pkg::lng_sts_t  sts,
  input  logic               in_accept,
  input  lng_pkg::lng_in_t   in_data,
  input  logic signed [14:0] target,
  input  logic [13:0]        maxred,
  output lng_pkg::lng_out_t  out_data,
  output logic               out_valid,
  input  logic               out_ready
);
  import lng_pkg::*;

  localparam int CW       = MAX_SAMPLES_LOG2 + 1;
  localparam int SQ_SHIFT = 2 * (24 - SAMPLE_WIDTH);

  // sample stage
  logic [SAMPLE_WIDTH-1:0]   raw, mag;
  logic [2*SAMPLE_WIDTH-1:0] mag_sq;
  logic [47:0] sq_r;
  logic        v1_r, l1_r;
  logic [63:0] sum_r;
  logic [CW-1:0] cnt_r;

  assign raw    = in_data.sample[SAMPLE_WIDTH-1:0];
  assign mag    = raw[SAMPLE_WIDTH-1] ? (~raw + 1'b1) : raw;
  assign mag_sq = mag * mag;

  // divider
  logic [63:0]   num_r, q_r;
  logic [CW-1:0] dcnt_r, rem_r;
  logic [CW:0]   rem2;
  logic          ge;

  assign rem2 = {rem_r, num_r[63]};
  assign ge   = rem2 >= {1'b0, dcnt_r};

  // log2
  logic [63:0] x_r;
  logic [5:0]  p_r;
  logic [30:0] y_r;
  logic [23:0] frac_r;
  logic [61:0] ysq;
  logic [31:0] ysh;
  logic [7:0]  pm;
  logic signed [31:0] l2;

  assign ysq = y_r * y_r;
  assign ysh = ysq[61:30];
  assign pm  = {2'b00, p_r} - 8'd62;
  assign l2  = $signed({pm, frac_r});

  // loudness and gain
  logic signed [63:0] lprod_r, lsum;
  logic signed [15:0] loud_r;
  logic signed [17:0] gd, lowlim, g1;
  logic signed [15:0] gain_r, gain_nxt;

  assign lsum   = lprod_r + LOUD_BIAS;
  assign gd     = 18'(target) - 18'(loud_r);
  assign lowlim = -$signed({4'b0000, maxred});

  always_comb begin
    g1 = (gd < lowlim) ? lowlim : gd;
    if (g1 > 18'sd32767)       gain_nxt = 16'sh7fff;
    else if (g1 < -18'sd32768) gain_nxt = 16'sh8000;
    else                       gain_nxt = g1[15:0];
  end

  // exp
  logic signed [39:0] e_r;
  logic signed [7:0]  n_r;
  logic [63:0] fprod;
  logic [29:0] ye_r;
  logic [30:0] term_r, pa_r;
  logic [31:0] esum_r;
  logic [60:0] tprod;
  logic [67:0] qprod;

  assign fprod = e_r[31:0] * LN2_Q32;
  assign tprod = term_r * ye_r;
  assign qprod = pa_r * lng_recip(cmd.exp_k);

  // output
  logic [6:0]  sh;
  logic [63:0] rnd;
  logic        big;
  lng_out_t    res;
  lng_out_t    out_r;
  logic        ovalid_r;

  assign sh  = 7'd14 - 7'(n_r);
  assign rnd = ({32'd0, esum_r} + (64'd1 << (sh - 7'd1))) >> sh;
  assign big = (n_r >= 8'sd8) || (rnd > LIN_MAX);

  always_comb begin
    res.loudness       = loud_r;
    res.gain_db        = gain_r;
    res.gain_linear    = big ? 24'hffffff : rnd[23:0];
    res.gain_saturated = big;
  end

  assign sts.last_seen = v1_r && l1_r;
  assign sts.norm_done = x_r[63];
  assign sts.out_free  = !ovalid_r || out_ready;
  assign out_data      = out_r;
  assign out_valid     = ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      l1_r     <= 1'b0;
      sum_r    <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      v1_r <= in_accept;
      if (in_accept) l1_r <= in_data.last;
      if (cmd.div_load) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else if (v1_r && (cnt_r != {CW{1'b1}})) begin
        sum_r <= sum_r + 64'(sq_r);
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.out_load)  ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) sq_r <= 48'(mag_sq) << SQ_SHIFT;
    if (cmd.div_load) begin
      num_r  <= sum_r;
      dcnt_r <= cnt_r;
      rem_r  <= '0;
      q_r    <= '0;
    end
    if (cmd.div_step) begin
      num_r <= {num_r[62:0], 1'b0};
      rem_r <= ge ? CW'(rem2 - {1'b0, dcnt_r}) : rem2[CW-1:0];
      q_r   <= {q_r[62:0], ge};
    end
    if (cmd.x_load) begin
      x_r <= ((dcnt_r == '0) ? 64'd0 : q_r) + EPS_Q62;
      p_r <= 6'd63;
    end
    if (cmd.norm_step) begin
      x_r <= {x_r[62:0], 1'b0};
      p_r <= p_r - 6'd1;
    end
    if (cmd.log_init) begin
      y_r    <= x_r[63:33];
      frac_r <= '0;
    end
    if (cmd.log_step) begin
      y_r    <= ysh[31] ? ysh[31:1] : ysh[30:0];
      frac_r <= {frac_r[22:0], ysh[31]};
    end
    if (cmd.lmul)   lprod_r <= 64'(l2) * C_LOG_Q20;
    if (cmd.lround) loud_r  <= 16'(lsum >>> 44);
    if (cmd.gain)   gain_r  <= gain_nxt;
    if (cmd.gmul)   e_r     <= 40'(gain_r) * K_Q32;
    if (cmd.fmul) begin
      n_r    <= e_r[39:32];
      ye_r   <= fprod[63:34];
      term_r <= 31'h40000000;
      esum_r <= 32'h40000000;
    end
    if (cmd.exp_a) pa_r <= tprod[60:30];
    if (cmd.exp_b) begin
      term_r <= qprod[66:36];
      esum_r <= esum_r + 32'(qprod[66:36]);
    end
    if (cmd.out_load) out_r <= res;
  end

endmodule

>>> rtl/loudness_normalizing_gain.sv
// ---------------------------------------------------------------------------
// loudness_normalizing_gain: per-track loudness measurement and gain
// Accumulates squared samples and, on the last one, reports loudness and gain.
// ---------------------------------------------------------------------------
// Feed every sample of a track, all channels in any order, one item per
// clock; mark the final sample with last. The square is registered on
// accept and summed the cycle after. When the last sample lands, intake
// stops while the datapath works out the result: a one-bit restoring
// divider for the mean square, leading-one normalization, log2 by
// repeated squaring, multiplies for loudness and gain, and the 12-term
// exp series (multiply, then reciprocal-divide, per term). Intake resumes
// once the result is loaded into the output register; a result that has
// not been taken yet waits there, and only the next track's result stalls
// behind it. Sums clear as the divider loads them. Registers (APB, word
// address): 0 target loudness, 1 max reduction, both in 1/256 dB; write
// them only while the block is idle.
// ---------------------------------------------------------------------------
module loudness_normalizing_gain #(
  parameter int SAMPLE_WIDTH     = lng_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_SAMPLES_LOG2 = lng_pkg::MAX_SAMPLES_LOG2_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lng_pkg::lng_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lng_pkg::lng_out_t         out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lng_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import lng_pkg::*;

  logic signed [14:0] target_r;
  logic [13:0]        maxred_r;
  logic               cfg_wr;
  logic               in_accept;
  lng_cmd_t           cmd;
  lng_sts_t           sts;

  // Register write completes in the access phase; pready never stalls.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      maxred_r <= MAXRED_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        CFG_IDX_TARGET: target_r <= pwdata[14:0];
        CFG_IDX_MAXRED: maxred_r <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // Read back the target sign-extended, the reduction zero-extended.
  always_comb begin
    case (paddr[2])
      CFG_IDX_TARGET: prdata = 32'(target_r);
      CFG_IDX_MAXRED: prdata = {18'd0, maxred_r};
      default:        prdata = '0;
    endcase
  end

  // Take a valid item whenever the sequencer sits in sample intake and no last sample is pending.
  assign in_accept = in_valid && in_ready;

  lng_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  lng_datapath #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .MAX_SAMPLES_LOG2 (MAX_SAMPLES_LOG2)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_accept (in_accept),
    .in_data   (in_data),
    .target    (target_r),
    .maxred    (maxred_r),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

>>> tb/sv/loudness_normalizing_gain_tb.sv
// ---------------------------------------------------------------------------
// loudness_normalizing_gain_tb: self-checking bench of the loudness gain block
// Drives tracks of samples with random gaps and output stalls, reprograms the
// target and reduction registers between phases, and compares every result
// with a bit-exact fixed-point predictor of the loudness and gain math or with hand-typed fields.
// ---------------------------------------------------------------------------
module loudness_normalizing_gain_tb;
  import lng_pkg::*;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  FULL_COUNT   = 131071;   // saturation point of the sample counter
  localparam int  RAND_ITEMS   = 1950;
  localparam logic [2:0] ADDR_TARGET = 3'd0;
  localparam logic [2:0] ADDR_MAXRED = 3'd4;

  // Which fields of a directed row are typed in by hand.
  typedef enum logic [1:0] {CHK_PRED, CHK_LEVEL, CHK_ALL} row_chk_t;

  typedef struct {
    logic signed [23:0] sample;
    logic               last;
    row_chk_t           chk;
    logic signed [15:0] loud;
    logic signed [15:0] gain;
    logic        [23:0] lin;
    logic               sat;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lng_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lng_out_t  out_data;
  logic      psel = 1'b0;
  logic      penable = 1'b0;
  logic      pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  loudness_normalizing_gain dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // Predictor state: registers and the running track sums.
  logic signed [14:0] cur_target = TARGET_RST;
  logic        [13:0] cur_maxred = MAXRED_RST;
  logic        [63:0] acc_square = '0;
  logic        [16:0] acc_count = '0;

  lng_out_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int tracks_sent = 0;
  int cycles = 0;
  int stall_left = 0;
  bit sink_idle = 1'b0;
  bit src_idle = 1'b0;

  // Mean square in Q.62: floor(sum * 2^16 / count), kept to 64 bits.
  function automatic logic [63:0] mean_square(logic [63:0] s, logic [16:0] c);
    logic [79:0] q;
    if (c == 0) return '0;
    q = {s, 16'h0} / c;
    return q[63:0];
  endfunction

  // log2 in Q.24 by leading one and repeated squaring of the mantissa.
  function automatic longint log2_fixed(logic [63:0] x);
    int p;
    logic [63:0] y, fr;
    p = 63;
    fr = '0;
    while (p > 0 && !x[p]) p--;
    y = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
    for (int i = 0; i < 24; i++) begin
      y = (y * y) >> 30;
      fr = fr << 1;
      if (y >= 64'h8000_0000) begin
        fr[0] = 1'b1;
        y = y >> 1;
      end
    end
    return (longint'(p - 62) <<< 24) + longint'(fr);
  endfunction

  function automatic longint loudness_of(logic [63:0] ms);
    longint t;
    logic [63:0] u;
    t = log2_fixed(ms + EPS_Q62) * 64'sd808071242 + (-64'sd185488900 <<< 24);
    u = t + (64'd1 << 43) + (64'd1 << 62);
    return longint'(u >> 44) - (64'sd1 <<< 18);
  endfunction

  // 10^(g/5120) in Q8.16 via 2^n * exp(frac * ln2) with a 12-term series.
  function automatic logic [23:0] linear_of(longint g, output logic sat);
    longint e, n;
    int sh;
    logic [63:0] b, f, y, total, term, res;
    e = g * 64'sd2786635;
    b = e + (64'd64 << 32);
    n = longint'(b >> 32) - 64;
    f = {32'h0, b[31:0]};
    y = (f * 64'd2977044472) >> 34;
    total = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 30) / k;
      total += term;
    end
    sat = 1'b0;
    if (n >= 8) begin
      sat = 1'b1;
      return 24'hFFFFFF;
    end
    sh = 14 - int'(n);
    if (sh > 62) return '0;
    res = (total + (64'd1 << (sh - 1))) >> sh;
    if (res > LIN_MAX) begin
      sat = 1'b1;
      return 24'hFFFFFF;
    end
    return res[23:0];
  endfunction

  // Advance the track sums by one accepted item; return 1 when it ends a track.
  function automatic bit track_step(lng_in_t it, output lng_out_t r);
    logic [23:0] mag;
    longint loud, g;
    logic s;
    mag = it.sample[23] ? (24'd0 - it.sample) : it.sample;
    if (it.sample == 24'h800000) mag = 24'h800000;
    if (acc_count < FULL_COUNT) begin
      acc_square += {40'h0, mag} * {40'h0, mag};
      acc_count++;
    end
    r = '0;
    if (!it.last) return 1'b0;
    loud = loudness_of(mean_square(acc_square, acc_count));
    g = longint'(cur_target) - loud;
    if (g < -longint'(cur_maxred)) g = -longint'(cur_maxred);
    if (g > 32767) g = 32767;
    if (g < -32768) g = -32768;
    r.loudness = loud[15:0];
    r.gain_db = g[15:0];
    r.gain_linear = linear_of(g, s);
    r.gain_saturated = s;
    acc_square = '0;
    acc_count = '0;
    return 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, $signed(got),
             $signed(want), results_seen);
  endtask

  // Present one item after a gap and hold it until accepted; queue the result when it ends a track.
  task automatic send_item(lng_in_t it, int gap, row_chk_t chk = CHK_PRED,
                           lng_out_t typed = '0);
    lng_out_t r;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    if (track_step(it, r)) begin
      // Hand-typed fields override the predictor, so the DUT is held to them.
      if (chk != CHK_PRED) begin
        r.loudness = typed.loudness;
        r.gain_db = typed.gain_db;
      end
      if (chk == CHK_ALL) begin
        r.gain_linear = typed.gain_linear;
        r.gain_saturated = typed.gain_saturated;
      end
      pending_results.insert(pending_results.size(), r);
      tracks_sent++;
    end
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Drain every result, let the datapath settle, then write both registers.
  task automatic program_regs(logic [31:0] target, logic [31:0] maxred);
    idle_input();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    for (int i = 0; i < 2; i++) begin
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = (i == 0) ? ADDR_TARGET : ADDR_MAXRED;
      pwdata = (i == 0) ? target : maxred;
      @(negedge clk);
      penable = 1'b1;
      @(negedge clk);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
    end
    cur_target = target[14:0];
    cur_maxred = maxred[13:0];
  endtask

  // One random track: per-track amplitude so loudness spreads over its range.
  task automatic random_track(int len);
    lng_in_t it;
    int shift;
    shift = $urandom_range(0, 23);
    for (int i = 0; i < len; i++) begin
      it.sample = $signed(24'($urandom)) >>> shift;
      if ($urandom_range(0, 40) == 0) it.sample = 24'h800000;
      it.last = (i == len - 1);
      send_item(it, src_idle ? $urandom_range(0, 16) : 0);
    end
  endtask

  // Result side: compare at the rising edge, draw the next stall on accept.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("loudness_normalizing_gain_tb: errors");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result loudness", 32'(out_data.loudness), 32'd0);
      end else begin
        lng_out_t w;
        w = pending_results.pop_front();
        if (out_data.loudness !== w.loudness)
          report("loudness", 32'(out_data.loudness), 32'(w.loudness));
        if (out_data.gain_db !== w.gain_db)
          report("gain_db", 32'(out_data.gain_db), 32'(w.gain_db));
        if (out_data.gain_linear !== w.gain_linear)
          report("gain_linear", {8'h0, out_data.gain_linear}, {8'h0, w.gain_linear});
        if (out_data.gain_saturated !== w.gain_saturated)
          report("gain_saturated", 32'(out_data.gain_saturated), 32'(w.gain_saturated));
      end
      results_seen++;
      stall_left = sink_idle ? $urandom_range(0, 16) : 0;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    row_t dir_rows[$];
    lng_in_t it;
    lng_out_t typed;
    int budget;
    int len;

    // Silence gives the floor loudness and a clipped boost; full scale sits at
    // the ceiling and is held by the default reduction limit.
    dir_rows = '{
      '{24'sd0,        1'b1, CHK_ALL,   -16'sd25777, 16'sd22193, 24'hFFFFFF, 1'b1},
      '{-24'sd8388608, 1'b1, CHK_LEVEL, -16'sd177,   -16'sd3072, 24'h0, 1'b0},
      '{24'sd8388607,  1'b1, CHK_PRED,  16'sd0, 16'sd0, 24'h0, 1'b0},
      '{24'sd1,        1'b1, CHK_PRED,  16'sd0, 16'sd0, 24'h0, 1'b0},
      '{-24'sd1,       1'b1, CHK_PRED,  16'sd0, 16'sd0, 24'h0, 1'b0},
      '{24'sd100,      1'b0, CHK_PRED,  16'sd0, 16'sd0, 24'h0, 1'b0},
      '{-24'sd100,     1'b0, CHK_PRED,  16'sd0, 16'sd0, 24'h0, 1'b0},
      '{24'sd8388607,  1'b0, CHK_PRED,  16'sd0, 16'sd0, 24'h0, 1'b0},
      '{24'sd0,        1'b1, CHK_PRED,  16'sd0, 16'sd0, 24'h0, 1'b0},
      '{24'sh555555,   1'b0, CHK_PRED,  16'sd0, 16'sd0, 24'h0, 1'b0},
      '{24'shAAAAAA,   1'b1, CHK_PRED,  16'sd0, 16'sd0, 24'h0, 1'b0},
      '{24'sd4096,     1'b1, CHK_PRED,  16'sd0, 16'sd0, 24'h0, 1'b0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      it.sample = dir_rows[i].sample;
      it.last = dir_rows[i].last;
      typed = '{dir_rows[i].loud, dir_rows[i].gain, dir_rows[i].lin, dir_rows[i].sat};
      send_item(it, i % 3, dir_rows[i].chk, typed);
    end

    // Phases: defaults kept, range extremes, out-of-range codes, random values.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        1: program_regs(-32'sd15360, 32'd0);
        2: program_regs(32'd0, 32'd15360);
        3: program_regs(32'h3FFF, 32'h3FFF);
        4: program_regs(32'h4000, 32'h0);
        5, 6: program_regs($urandom, $urandom);
        default: ;
      endcase
      budget = RAND_ITEMS / 7;
      while (budget > 0) begin
        src_idle = $urandom_range(0, 2) != 0;
        sink_idle = $urandom_range(0, 2) != 0;
        if ($urandom_range(0, 9) == 0) len = $urandom_range(25, 150);
        else len = $urandom_range(1, 24);
        random_track(len);
        budget -= len;
      end
    end

    idle_input();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("covered %0d samples over %0d tracks, %0d results checked",
             samples_sent, tracks_sent, results_seen);
    $display("register phases: defaults, range limits, out-of-range codes, random");
    if (errors == 0 && pending_results.size() == 0)
      $display("loudness_normalizing_gain_tb: clean");
    else
      $display("loudness_normalizing_gain_tb: errors");
    $finish;
  end

endmodule

>>> loudness_normalizing_gain.f
rtl/lng_pkg.sv
rtl/lng_ctrl.sv
rtl/lng_datapath.sv
rtl/loudness_normalizing_gain.sv
tb/sv/loudness_normalizing_gain_tb.sv
